// ----- src/csw_pkg.sv -----
// Shared types and constants for the current sense window detector.
// No dependencies; imported by every module of the block.
package csw_pkg;

	// Register and field widths fixed by the register map
	localparam int LVL_W = 14;
	localparam int CNT_W = 7;
	localparam int GAIN_W = 24;
	localparam int GAIN_FRAC = 16;
	localparam int LEVEL_W = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 3;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CALIB_LEVEL = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ABS_ZERO_LEVEL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BELOW_MARGIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_COUNT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_WINDOW = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_GAIN = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_OVER_LEVEL = 3'd7;

	// Reset values of the registers
	localparam logic [LVL_W-1:0] CALIB_LEVEL_RST = 14'd10750;
	localparam logic [LVL_W-1:0] ABS_ZERO_LEVEL_RST = 14'd10750;
	localparam logic [LVL_W-1:0] BELOW_MARGIN_RST = 14'd500;
	localparam logic [CNT_W-1:0] ON_COUNT_RST = 7'd5;
	localparam logic [CNT_W-1:0] SAMPLES_PER_WINDOW_RST = 7'd10;
	localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST = 24'd1024;
	localparam logic [CNT_W-1:0] MAX_LEVEL_RST = 7'd100;
	localparam logic [CNT_W-1:0] OVER_LEVEL_RST = 7'd127;

	// Below-count saturates here
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// Event codes of a result
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ON     = 2'd1,
		EV_OFF    = 2'd2,
		EV_CHANGE = 2'd3
	} event_t;

	// Configuration register file contents
	typedef struct packed {
		logic [LVL_W-1:0]  calib_level;
		logic [LVL_W-1:0]  abs_zero_level;
		logic [LVL_W-1:0]  below_margin;
		logic [CNT_W-1:0]  on_count;
		logic [CNT_W-1:0]  samples_per_window;
		logic [GAIN_W-1:0] level_gain;
		logic [CNT_W-1:0]  max_level;
		logic [CNT_W-1:0]  over_level;
	} cfg_t;

endpackage

// ----- src/current_sense_window_detector_core.sv -----
// Top level of the current sense window detector: register file and the
// three processing stages. Depends on csw_pkg, csw_window, csw_scale, csw_decide.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   sample
//   result    out_valid / out_ready event_res, window_end, powered,
//                                   report_level, over_current, window_min
//   config    cfg_we (no wait)      cfg_index, cfg_data
//
// One sample per cycle sustained while results are taken; every sample gives one result, registered
// through the input register, window stage, gain multiply and result register.
// The gain multiply of the difference magnitude sets the critical path.
// arst_n clears all control and window state and loads register reset values.
// A stalled result back-fills the empty stages before in_ready drops.
module current_sense_window_detector_core import csw_pkg::*; #(
	parameter int SAMPLE_BITS = 14,
	parameter int MAX_WINDOW = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_BITS-1:0]    sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                event_res,
	output logic                      window_end,
	output logic                      powered,
	output logic signed [LEVEL_W-1:0] report_level,
	output logic                      over_current,
	output logic [SAMPLE_BITS-1:0]    window_min
);

	localparam int MAG_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;
	localparam int QW = MAG_W + GAIN_W - GAIN_FRAC;

	cfg_t                   cfg_q;

	logic                   w_valid;
	logic                   w_ready;
	logic                   w_close;
	logic [SAMPLE_BITS-1:0] w_min;
	logic [CNT_W-1:0]       w_cnt;
	logic                   w_rel_neg;
	logic [MAG_W-1:0]       w_rel_mag;
	logic                   w_abs_neg;
	logic [MAG_W-1:0]       w_abs_mag;

	logic                   s_valid;
	logic                   s_ready;
	logic                   s_close;
	logic [SAMPLE_BITS-1:0] s_min;
	logic [CNT_W-1:0]       s_cnt;
	logic                   s_rel_neg;
	logic [QW-1:0]          s_rel_q;
	logic                   s_abs_neg;
	logic [QW-1:0]          s_abs_q;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calib_level <= CALIB_LEVEL_RST;
			cfg_q.abs_zero_level <= ABS_ZERO_LEVEL_RST;
			cfg_q.below_margin <= BELOW_MARGIN_RST;
			cfg_q.on_count <= ON_COUNT_RST;
			cfg_q.samples_per_window <= SAMPLES_PER_WINDOW_RST;
			cfg_q.level_gain <= LEVEL_GAIN_RST;
			cfg_q.max_level <= MAX_LEVEL_RST;
			cfg_q.over_level <= OVER_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CALIB_LEVEL: cfg_q.calib_level <= cfg_data[LVL_W-1:0];
				REG_ABS_ZERO_LEVEL: cfg_q.abs_zero_level <= cfg_data[LVL_W-1:0];
				REG_BELOW_MARGIN: cfg_q.below_margin <= cfg_data[LVL_W-1:0];
				REG_ON_COUNT: cfg_q.on_count <= cfg_data[CNT_W-1:0];
				REG_SAMPLES_PER_WINDOW: cfg_q.samples_per_window <= cfg_data[CNT_W-1:0];
				REG_LEVEL_GAIN: cfg_q.level_gain <= cfg_data[GAIN_W-1:0];
				REG_MAX_LEVEL: cfg_q.max_level <= cfg_data[CNT_W-1:0];
				REG_OVER_LEVEL: cfg_q.over_level <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	csw_window #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_WINDOW(MAX_WINDOW)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(w_valid),
		.out_ready(w_ready),
		.close(w_close),
		.win_min(w_min),
		.win_cnt(w_cnt),
		.rel_neg(w_rel_neg),
		.rel_mag(w_rel_mag),
		.abs_neg(w_abs_neg),
		.abs_mag(w_abs_mag)
	);

	csw_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(w_valid),
		.in_ready(w_ready),
		.close_i(w_close),
		.min_i(w_min),
		.cnt_i(w_cnt),
		.rel_neg_i(w_rel_neg),
		.rel_mag_i(w_rel_mag),
		.abs_neg_i(w_abs_neg),
		.abs_mag_i(w_abs_mag),
		.out_valid(s_valid),
		.out_ready(s_ready),
		.close_o(s_close),
		.min_o(s_min),
		.cnt_o(s_cnt),
		.rel_neg_o(s_rel_neg),
		.rel_q_o(s_rel_q),
		.abs_neg_o(s_abs_neg),
		.abs_q_o(s_abs_q)
	);

	csw_decide #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_decide (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_valid),
		.in_ready(s_ready),
		.close_i(s_close),
		.min_i(s_min),
		.cnt_i(s_cnt),
		.rel_neg_i(s_rel_neg),
		.rel_q_i(s_rel_q),
		.abs_neg_i(s_abs_neg),
		.abs_q_i(s_abs_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.window_end(window_end),
		.powered(powered),
		.report_level(report_level),
		.over_current(over_current),
		.window_min(window_min)
	);

`ifndef ASSERT_OFF
	// Events only come with a closing sample
	a_event_at_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != EV_NONE)) |-> window_end)
		else $error("event without window end");

	// Power events agree with the reported flag
	a_on_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_ON)) |-> powered)
		else $error("power-on event with flag low");

	a_off_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_OFF)) |-> !powered)
		else $error("power-off event with flag high");

	// Report level never exceeds the clamp
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (report_level <= $signed({1'b0, cfg_q.max_level})))
		else $error("report level above clamp");

	// Input stalls only when every stage is full and the result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && w_valid && s_valid))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- src/csw_window.sv -----
// Window accumulation: input register, running minimum, below-count and
// sample index, plus the reference differences of a closing window. Uses csw_pkg.
module csw_window import csw_pkg::*; #(
	parameter int SAMPLE_BITS = 14,
	parameter int MAX_WINDOW = 64,
	localparam int MAG_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   close,
	output logic [SAMPLE_BITS-1:0] win_min,
	output logic [CNT_W-1:0]       win_cnt,
	output logic                   rel_neg,
	output logic [MAG_W-1:0]       rel_mag,
	output logic                   abs_neg,
	output logic [MAG_W-1:0]       abs_mag
);

	localparam int IDX_W = $clog2(MAX_WINDOW + 1);
	localparam int CW = (IDX_W > CNT_W) ? IDX_W : CNT_W;
	localparam int DW = MAG_W + 1;
	localparam logic [CW-1:0] MAXW = CW'(MAX_WINDOW);

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic                   adv_s2;

	logic [SAMPLE_BITS-1:0] min_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;

	logic [CW-1:0]          spw_w;
	logic [CW-1:0]          n_eff;
	logic [CW-1:0]          idx_inc;
	logic                   close_w;
	logic [LVL_W:0]         thr;
	logic                   loaded;
	logic [SAMPLE_BITS-1:0] min_new;
	logic [CNT_W-1:0]       cnt_new;
	logic [DW-1:0]          rel_d;
	logic [DW-1:0]          abs_d;

	// Move s1 into s2 when s2 is empty or drains
	assign adv_s2 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign out_valid = valid_s2;

	// Effective window length: zero reads as one, clamp to the maximum
	assign spw_w = CW'(cfg.samples_per_window);
	always_comb begin
		if (spw_w == '0) begin
			n_eff = CW'(1);
		end else if (spw_w > MAXW) begin
			n_eff = MAXW;
		end else begin
			n_eff = spw_w;
		end
	end

	assign idx_inc = CW'(idx_q) + CW'(1);
	assign close_w = (idx_inc >= n_eff);

	// Loaded test against calibration minus margin; a negative threshold counts nothing
	assign thr = {1'b0, cfg.calib_level} - {1'b0, cfg.below_margin};
	assign loaded = !thr[LVL_W] && (MAG_W'(sample_s1) < MAG_W'(thr[LVL_W-1:0]));

	assign min_new = (sample_s1 < min_q) ? sample_s1 : min_q;
	assign cnt_new = (loaded && (cnt_q != CNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;

	// Reference minus window minimum, split into sign and magnitude
	assign rel_d = {1'b0, MAG_W'(cfg.calib_level)} - {1'b0, MAG_W'(min_new)};
	assign abs_d = {1'b0, MAG_W'(cfg.abs_zero_level)} - {1'b0, MAG_W'(min_new)};

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	// Window state: clear on the closing sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (adv_s2) begin
			if (close_w) begin
				min_q <= '1;
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				min_q <= min_new;
				cnt_q <= cnt_new;
				idx_q <= idx_inc[IDX_W-1:0];
			end
		end
	end

	// Stage two register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			close <= close_w;
			win_min <= min_new;
			win_cnt <= cnt_new;
			rel_neg <= rel_d[DW-1];
			rel_mag <= rel_d[DW-1] ? MAG_W'(~rel_d + DW'(1)) : MAG_W'(rel_d);
			abs_neg <= abs_d[DW-1];
			abs_mag <= abs_d[DW-1] ? MAG_W'(~abs_d + DW'(1)) : MAG_W'(abs_d);
		end
	end

endmodule

// ----- src/csw_scale.sv -----
// Gain stage: multiplies both difference magnitudes by the Q8.16 gain
// and registers the integer parts. Uses csw_pkg.
module csw_scale import csw_pkg::*; #(
	parameter int SAMPLE_BITS = 14,
	localparam int MAG_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W,
	localparam int QW = MAG_W + GAIN_W - GAIN_FRAC
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   close_i,
	input  logic [SAMPLE_BITS-1:0] min_i,
	input  logic [CNT_W-1:0]       cnt_i,
	input  logic                   rel_neg_i,
	input  logic [MAG_W-1:0]       rel_mag_i,
	input  logic                   abs_neg_i,
	input  logic [MAG_W-1:0]       abs_mag_i,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   close_o,
	output logic [SAMPLE_BITS-1:0] min_o,
	output logic [CNT_W-1:0]       cnt_o,
	output logic                   rel_neg_o,
	output logic [QW-1:0]          rel_q_o,
	output logic                   abs_neg_o,
	output logic [QW-1:0]          abs_q_o
);

	localparam int PW = MAG_W + GAIN_W;

	logic          valid_s3;
	logic [PW-1:0] rel_prod;
	logic [PW-1:0] abs_prod;

	assign in_ready = !valid_s3 || out_ready;
	assign out_valid = valid_s3;

	assign rel_prod = PW'(rel_mag_i) * PW'(cfg.level_gain);
	assign abs_prod = PW'(abs_mag_i) * PW'(cfg.level_gain);

	// Hold or advance stage three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Drop the fraction bits of the products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			close_o <= close_i;
			min_o <= min_i;
			cnt_o <= cnt_i;
			rel_neg_o <= rel_neg_i;
			rel_q_o <= rel_prod[PW-1:GAIN_FRAC];
			abs_neg_o <= abs_neg_i;
			abs_q_o <= abs_prod[PW-1:GAIN_FRAC];
		end
	end

endmodule

// ----- src/csw_decide.sv -----
// Level saturation, on/off hysteresis, change detect and the result register.
// Holds the per-window level state. Uses csw_pkg.
module csw_decide import csw_pkg::*; #(
	parameter int SAMPLE_BITS = 14,
	localparam int MAG_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W,
	localparam int QW = MAG_W + GAIN_W - GAIN_FRAC
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      close_i,
	input  logic [SAMPLE_BITS-1:0]    min_i,
	input  logic [CNT_W-1:0]          cnt_i,
	input  logic                      rel_neg_i,
	input  logic [QW-1:0]             rel_q_i,
	input  logic                      abs_neg_i,
	input  logic [QW-1:0]             abs_q_i,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                event_res,
	output logic                      window_end,
	output logic                      powered,
	output logic signed [LEVEL_W-1:0] report_level,
	output logic                      over_current,
	output logic [SAMPLE_BITS-1:0]    window_min
);

	localparam logic [CNT_W-1:0] OFF_LIMIT = 7'd3;
	localparam logic signed [LEVEL_W:0] CHANGE_STEP = 9'sd2;
	localparam logic [QW-1:0] POS_LIMIT = QW'(127);
	localparam logic [QW-1:0] NEG_LIMIT = QW'(128);

	logic                      valid_o;
	logic                      adv;

	logic [SAMPLE_BITS-1:0]    last_min_q;
	logic signed [LEVEL_W-1:0] level_now_q;
	logic signed [LEVEL_W-1:0] abs_level_q;
	logic                      on_q;

	logic signed [LEVEL_W-1:0] rel_lvl;
	logic signed [LEVEL_W-1:0] abs_lvl;
	logic signed [LEVEL_W:0]   delta;
	logic                      changed;
	logic                      on_new;
	event_t                    ev;
	logic [SAMPLE_BITS-1:0]    last_min_new;
	logic signed [LEVEL_W-1:0] level_new;
	logic signed [LEVEL_W-1:0] abs_new;
	logic signed [LEVEL_W:0]   rep_sum;
	logic signed [LEVEL_W:0]   rep_max;
	logic signed [LEVEL_W-1:0] rep;
	logic                      oc;

	// Saturate a signed quotient to the 8-bit signed range
	function automatic logic signed [LEVEL_W-1:0] sat_level(
		input logic          neg,
		input logic [QW-1:0] q
	);
		logic signed [LEVEL_W-1:0] r;
		if (neg) begin
			r = (q > NEG_LIMIT) ? LEVEL_W'(NEG_LIMIT) : LEVEL_W'(0) - q[LEVEL_W-1:0];
		end else begin
			r = (q > POS_LIMIT) ? LEVEL_W'(POS_LIMIT) : q[LEVEL_W-1:0];
		end
		return r;
	endfunction

	assign in_ready = !valid_o || out_ready;
	assign adv = in_valid && in_ready;
	assign out_valid = valid_o;

	assign rel_lvl = sat_level(rel_neg_i, rel_q_i);
	assign abs_lvl = sat_level(abs_neg_i, abs_q_i);

	assign delta = {rel_lvl[LEVEL_W-1], rel_lvl} - {level_now_q[LEVEL_W-1], level_now_q};
	assign changed = (delta >= CHANGE_STEP) || (delta <= -CHANGE_STEP);

	// Hysteresis on the below-count; change detect only while on
	always_comb begin
		on_new = on_q;
		ev = EV_NONE;
		if (close_i) begin
			priority if (cnt_i > cfg.on_count && !on_q) begin
				on_new = 1'b1;
				ev = EV_ON;
			end else if (on_q) begin
				priority if (cnt_i < OFF_LIMIT) begin
					on_new = 1'b0;
					ev = EV_OFF;
				end else if (changed) begin
					ev = EV_CHANGE;
				end else begin
				end
			end else begin
			end
		end
	end

	assign last_min_new = close_i ? min_i : last_min_q;
	assign level_new = close_i ? rel_lvl : level_now_q;
	assign abs_new = close_i ? abs_lvl : abs_level_q;

	// Report level: level plus on flag, clamped above
	assign rep_sum = {level_new[LEVEL_W-1], level_new} + (LEVEL_W + 1)'(on_new);
	assign rep_max = {2'b00, cfg.max_level};
	assign rep = (rep_sum > rep_max) ? rep_max[LEVEL_W-1:0] : rep_sum[LEVEL_W-1:0];
	assign oc = ($signed({1'b0, cfg.over_level}) <= abs_new);

	// Window level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_min_q <= '1;
			level_now_q <= '0;
			abs_level_q <= '0;
			on_q <= 1'b0;
		end else if (adv) begin
			last_min_q <= last_min_new;
			level_now_q <= level_new;
			abs_level_q <= abs_new;
			on_q <= on_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (in_ready) begin
			valid_o <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_res <= ev;
			window_end <= close_i;
			powered <= on_new;
			report_level <= rep;
			over_current <= oc;
			window_min <= last_min_new;
		end
	end

endmodule
